### rtl/srpt_pkg.sv
// Shared types, constants and the thinning decision for the skeleton thinning block.
`default_nettype none

package srpt_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 4;
    // row counter runs up to height + 1 during the trailing flush row
    localparam int ROW_W      = 14;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic pixel_in;
        logic flush;
    } in_word_t;

    typedef struct packed {
        logic pixel_out;
        logic out_valid;
        logic frame_end;
    } out_word_t;

    // where the decided pixel sits in the image
    typedef struct packed {
        logic decide;
        logic n_ok;
        logic s_ok;
        logic w_ok;
        logic e_ok;
        logic fend;
        logic w_one;
    } pos_flags_t;

    // ring order: 0 N, 1 NE, 2 E, 3 SE, 4 S, 5 SW, 6 W, 7 NW
    // A group starts where a set bit follows a clear one, unless it is an edge
    // neighbor joined to the edge neighbor two steps back across a clear corner.
    // No start at all with bits set means one closed group.
    function automatic logic thin_clear(input logic centre, input logic [7:0] ring);
        logic [7:0] starts;
        logic       multi;
        logic       few;
        for (int i = 0; i < 8; i++) begin
            starts[i] = ring[i] & ~ring[(i + 7) % 8] & ~(((i % 2) == 0) & ring[(i + 6) % 8]);
        end
        multi = |(ring & (ring - 8'd1));
        few   = ~|(starts & (starts - 8'd1));
        return centre & multi & few;
    endfunction

endpackage

`default_nettype wire

### rtl/srpt_ram.sv
// Simple dual-port RAM, one write and one registered read port, read-first.
`default_nettype none

module srpt_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // same-address read and write returns the old word
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/skeleton_redundant_pixel_thinning.sv
// Top level: streaming 8-connectivity skeleton thinning over two line memories.
//
//  channel | dir | handshake        | word
//  s_      | in  | s_valid/s_ready  | in_word_t  {pixel_in, flush}
//  m_      | out | m_valid/m_ready  | out_word_t {pixel_out, out_valid, frame_end}
//  cfg_    | in  | cfg_we           | cfg_index, cfg_wdata (image_width, image_height)
//
// One word per clock while m_ready holds; each word passes the read stage, then the m_ register.
// Each word does one read on each line memory, one write on the raw line memory and at most
// one write on the decided line memory; the decision sits in one stage after the memory read.
// Reset is synchronous; memories are not cleared, stale entries are masked as outside.
// A stalled m_ holds its word while one more word can still be taken into the pipe.
`default_nettype none

module skeleton_redundant_pixel_thinning
    import srpt_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = (AW > WIDTH_W) ? AW : WIDTH_W;
    localparam int WCAP = (MAX_WIDTH > (2 ** WIDTH_W - 1)) ? (2 ** WIDTH_W - 1) : MAX_WIDTH;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic [WIDTH_W-1:0]  weff;
    logic [HEIGHT_W-1:0] heff;
    logic [CW-1:0]       weff_c, wm1, cm1;
    logic [ROW_W-1:0]    h_r;
    logic [AW-1:0]       col_addr, qcol;
    logic                accept, cz, col_last, a_last, raw_bit;
    pos_flags_t          flags;

    // stage after the memory read
    logic          st1_valid_reg;
    logic          st1_raw_reg;
    pos_flags_t    st1_flags_reg;
    logic [AW-1:0] st1_qcol_reg;
    logic          st1_fwd_hit_reg, st1_fwd_bit_reg;

    // 3x3 window, right column comes from the two memory reads and the staged input pixel
    logic tl_reg, tc_reg, ml_reg, mc_reg, bl_reg, bc_reg;

    logic       raw_up, dec_up, tr, res, dec_we, b_adv, fwd_hit;
    logic [7:0] ring;
    out_word_t  out_next;
    out_word_t  m_data_reg;
    logic       m_valid_reg;

    always_comb begin
        if (width_reg == '0) begin
            weff = WIDTH_W'(1);
        end else if (int'(width_reg) > WCAP) begin
            weff = WIDTH_W'(WCAP);
        end else begin
            weff = width_reg;
        end
        heff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign weff_c   = CW'(weff);
    assign wm1      = weff_c - CW'(1);
    assign cm1      = col_reg - CW'(1);
    assign h_r      = ROW_W'(heff);
    assign col_addr = col_reg[AW-1:0];
    assign qcol     = cz ? wm1[AW-1:0] : cm1[AW-1:0];

    assign cz       = (col_reg == '0);
    assign col_last = (col_reg == wm1);
    assign a_last   = cz && (row_reg == h_r + ROW_W'(1));
    assign accept   = s_valid && s_ready;
    assign raw_bit  = s_data.pixel_in && !s_data.flush && (row_reg < h_r);

    // position of the pixel one row and one column back
    always_comb begin
        flags.decide = cz ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));
        flags.n_ok   = cz ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(2));
        flags.s_ok   = cz ? (row_reg <= h_r) : (row_reg < h_r);
        flags.w_ok   = cz ? (weff != WIDTH_W'(1)) : (col_reg != CW'(1));
        flags.e_ok   = !cz;
        flags.fend   = a_last;
        flags.w_one  = (weff == WIDTH_W'(1));
    end

    always_comb begin
        priority if (a_last) begin
            col_next = '0;
            row_next = '0;
        end else if (col_last) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_wdata[WIDTH_W-1:0];
            end else begin
                height_reg <= cfg_wdata[HEIGHT_W-1:0];
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // raw pixels one row back
    srpt_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_raw_line (
        .clk   (aclk),
        .we    (accept),
        .waddr (col_addr),
        .wdata (raw_bit),
        .re    (accept),
        .raddr (col_addr),
        .rdata (raw_up)
    );

    // decided pixels two rows back
    srpt_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_dec_line (
        .clk   (aclk),
        .we    (dec_we),
        .waddr (st1_qcol_reg),
        .wdata (res),
        .re    (accept),
        .raddr (col_addr),
        .rdata (dec_up)
    );

    assign b_adv   = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st1_valid_reg || b_adv;
    assign dec_we  = b_adv && st1_flags_reg.decide;
    // narrow images read the decision being written in the same cycle
    assign fwd_hit = dec_we && (st1_qcol_reg == col_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (accept) begin
            st1_valid_reg <= 1'b1;
        end else if (b_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_raw_reg     <= raw_bit;
            st1_flags_reg   <= flags;
            st1_qcol_reg    <= qcol;
            st1_fwd_hit_reg <= fwd_hit;
            st1_fwd_bit_reg <= res;
        end
    end

    assign tr = st1_fwd_hit_reg ? st1_fwd_bit_reg : dec_up;

    always_comb begin
        ring[0] = tc_reg      & st1_flags_reg.n_ok;
        ring[1] = tr          & st1_flags_reg.n_ok & st1_flags_reg.e_ok;
        ring[2] = raw_up      & st1_flags_reg.e_ok;
        ring[3] = st1_raw_reg & st1_flags_reg.s_ok & st1_flags_reg.e_ok;
        ring[4] = bc_reg      & st1_flags_reg.s_ok;
        ring[5] = bl_reg      & st1_flags_reg.s_ok & st1_flags_reg.w_ok;
        ring[6] = ml_reg      & st1_flags_reg.w_ok;
        ring[7] = tl_reg      & st1_flags_reg.n_ok & st1_flags_reg.w_ok;
        res     = mc_reg & ~thin_clear(mc_reg, ring);
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            tl_reg <= tc_reg;
            // single-column image: the pixel above is the one just decided
            tc_reg <= st1_flags_reg.w_one ? res : tr;
            ml_reg <= res;
            mc_reg <= raw_up;
            bl_reg <= bc_reg;
            bc_reg <= st1_raw_reg;
        end
    end

    always_comb begin
        out_next.pixel_out = st1_flags_reg.decide & res;
        out_next.out_valid = st1_flags_reg.decide;
        out_next.frame_end = st1_flags_reg.decide & st1_flags_reg.fend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < weff_c)
        else $error("column counter beyond image width");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && a_last && !cfg_we |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap after the last word of a frame");

    a_fwd_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fwd_hit |-> (weff <= WIDTH_W'(2)))
        else $error("decided-line forwarding hit on a wide image");

    a_fend_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.frame_end |-> m_data_reg.out_valid)
        else $error("frame end on a word without a real pixel");

endmodule

`default_nettype wire
